// File: design/pwmix_pkg.sv
// pwmix_pkg: shared types, widths and constants of the wavetable mixer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package pwmix_pkg;

  localparam int VOICES                 = 64;
  localparam int WAVE_DEPTH             = 2048;
  localparam int ENVELOPE_DEPTH         = 256;
  localparam int PHASE_FRACTION_BITS    = 8;
  localparam int ENVELOPE_FRACTION_BITS = 7;

  localparam int VOICE_IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int WAVE_AW     = $clog2(WAVE_DEPTH);
  localparam int ENV_AW      = $clog2(ENVELOPE_DEPTH);

  localparam int OP_W       = 2;
  localparam int INC_W      = 16;
  localparam int ADDR_W     = 11;
  localparam int SAMPLE_W   = 8;
  localparam int LEVEL_W    = 8;
  localparam int DUTY_W     = 11;
  localparam int LEN_W      = 12;
  localparam int ENV_LEN_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam int PHASE_W   = 20;
  localparam int ENV_POS_W = 15;

  localparam int PROD_W = SAMPLE_W + LEVEL_W + 1;
  localparam int SUM_W  = PROD_W + VOICE_IDX_W;
  localparam int MIX_SHIFT = 8;
  localparam int SHR_W  = SUM_W - MIX_SHIFT;
  localparam int CLIP_W = (SHR_W > DUTY_W + 1) ? SHR_W : DUTY_W + 1;

  localparam int MIX_CLIP = 1016;
  localparam int DUTY_MID = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_NOTE_ON = 2'd1,
    OP_WAVE_WR = 2'd2,
    OP_ENV_WR  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE_LEN    = 2'd0,
    CFG_SUSTAIN_LEN = 2'd1,
    CFG_ATTACK_LEN  = 2'd2,
    CFG_ENV_LEN     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [INC_W-1:0]     increment;
    logic [PHASE_W-1:0]   phase;
    logic [ENV_POS_W-1:0] env_pos;
  } voice_t;

endpackage

`default_nettype wire

// File: design/pwmix_if.sv
// pwmix channel interfaces: input items, result items, register writes
// depends on pwmix_pkg
`default_nettype none

interface pwmix_item_if;
  logic                                     valid;
  logic                                     ready;
  pwmix_pkg::op_e                           op;
  logic [pwmix_pkg::INC_W-1:0]              increment;
  logic [pwmix_pkg::ADDR_W-1:0]             table_address;
  logic signed [pwmix_pkg::SAMPLE_W-1:0]    wave_sample;
  logic [pwmix_pkg::LEVEL_W-1:0]            envelope_level;

  modport source (output valid, op, increment, table_address, wave_sample,
                  envelope_level, input ready);
  modport sink   (input valid, op, increment, table_address, wave_sample,
                  envelope_level, output ready);
endinterface

interface pwmix_result_if;
  logic                          valid;
  logic                          ready;
  logic [pwmix_pkg::DUTY_W-1:0]  pwm_duty;

  modport source (output valid, pwm_duty, input ready);
  modport sink   (input valid, pwm_duty, output ready);
endinterface

interface pwmix_cfg_if;
  logic                              valid;
  logic                              ready;
  pwmix_pkg::cfg_idx_e               index;
  logic [pwmix_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/polyphonic_wavetable_mixer.sv
// polyphonic_wavetable_mixer: voice state, wave and envelope memories, tick sweep and mix
// depends on pwmix_pkg and the interfaces in pwmix_if
//
//   channel   dir  handshake     payload
//   item_i    in   valid/ready   op, increment, table_address, wave_sample, envelope_level
//   result_o  out  valid/ready   pwm_duty
//   cfg_i     in   valid/ready   index, data
//
// note-on and store writes are written straight into memory; a tick sweeps all voices
// (one voice memory read per cycle over all voices, then a drain of the sweep pipeline and the emit)
// the voice memory has one valid bit per entry, cleared by reset, so no clearing pass
// a finished tick waits in the emit state while the result register is still full;
// no item is taken meanwhile, the result register holds its item until it is taken
`default_nettype none

module polyphonic_wavetable_mixer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pwmix_item_if.sink         item_i,
  pwmix_result_if.source     result_o,
  pwmix_cfg_if.sink          cfg_i
);
  import pwmix_pkg::*;

  localparam int ACC_PH_W = PHASE_W + 1;
  localparam int LIM_W    = ENV_LEN_W + ENVELOPE_FRACTION_BITS + 1;

  logic [LEN_W-1:0]     wave_len_q, sustain_len_q, attack_len_q;
  logic [ENV_LEN_W-1:0] env_len_q;

  state_e state_q, state_d;

  logic [VOICE_IDX_W-1:0] cnt_q, next_voice_q;
  logic                   in_ready, issue, emit, in_acc, pipe_busy;

  voice_t voice_mem [VOICES];
  logic [VOICES-1:0] voice_ok_q;
  voice_t            voice_rd_q;
  logic              entry_ok_q;

  logic signed [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [LEVEL_W-1:0]         env_mem [ENVELOPE_DEPTH];

  logic                   vm_we;
  logic [VOICE_IDX_W-1:0] vm_waddr;
  voice_t                 vm_wdata;

  logic                   s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [VOICE_IDX_W-1:0] s1_addr_q, s2_addr_q;
  logic [INC_W-1:0]       s2_inc_q;
  logic [PHASE_W-1:0]     s2_phase_q;
  logic [ENV_POS_W-1:0]   s2_pos_q;

  logic signed [SAMPLE_W-1:0] wave_rd_q;
  logic [LEVEL_W-1:0]         env_rd_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SUM_W-1:0]    acc_q;

  logic                 out_valid_q;
  logic [DUTY_W-1:0]    out_duty_q;

  voice_t               vcur;
  logic [ACC_PH_W-1:0]  ph_sum, ph_back, wrap_at, loop_back, attack_at;
  logic [PHASE_W-1:0]   ph_new;
  logic [LIM_W-1:0]     env_limit, pos_inc;
  logic                 env_step;
  logic [ENV_POS_W-1:0] pos_new;

  logic signed [SHR_W-1:0]  mix_shr;
  logic signed [CLIP_W-1:0] mix_ext, mix_clip, duty_full;

  // register port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_len_q    <= LEN_W'(2048);
      sustain_len_q <= LEN_W'(2048);
      attack_len_q  <= '0;
      env_len_q     <= ENV_LEN_W'(256);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WAVE_LEN:    wave_len_q    <= cfg_i.data[LEN_W-1:0];
        CFG_SUSTAIN_LEN: sustain_len_q <= cfg_i.data[LEN_W-1:0];
        CFG_ATTACK_LEN:  attack_len_q  <= cfg_i.data[LEN_W-1:0];
        CFG_ENV_LEN:     env_len_q     <= cfg_i.data[ENV_LEN_W-1:0];
      endcase
    end
  end

  // control
  assign in_acc    = item_i.valid && in_ready;
  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && item_i.op == OP_TICK) state_d = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (cnt_q == VOICE_IDX_W'(VOICES - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q) state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = (state_q == ST_IDLE);
    issue    = (state_q == ST_SWEEP);
    emit     = (state_q == ST_EMIT) && !out_valid_q;
  end

  assign item_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      next_voice_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && item_i.op == OP_TICK) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (in_acc && item_i.op == OP_NOTE_ON) begin
        next_voice_q <= (next_voice_q == VOICE_IDX_W'(VOICES - 1)) ? '0
                                                                   : next_voice_q + 1'b1;
      end
    end
  end

  // voice memory write port: note-on or write-back of the sweep
  always_comb begin
    if (s2_v_q) begin
      vm_we    = 1'b1;
      vm_waddr = s2_addr_q;
      vm_wdata = '{increment: s2_inc_q, phase: s2_phase_q, env_pos: pos_new};
    end else begin
      vm_we    = in_acc && item_i.op == OP_NOTE_ON;
      vm_waddr = next_voice_q;
      vm_wdata = '{increment: item_i.increment, phase: '0, env_pos: '0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (vm_we) voice_mem[vm_waddr] <= vm_wdata;
    voice_rd_q <= voice_mem[cnt_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_ok_q <= '0;
      entry_ok_q <= 1'b0;
    end else begin
      if (vm_we) voice_ok_q[vm_waddr] <= 1'b1;
      entry_ok_q <= voice_ok_q[cnt_q];
    end
  end

  // wave and envelope memories
  always_ff @(posedge clk_i) begin
    if (in_acc && item_i.op == OP_WAVE_WR) begin
      wave_mem[WAVE_AW'(item_i.table_address)] <= item_i.wave_sample;
    end
    if (in_acc && item_i.op == OP_ENV_WR) begin
      env_mem[ENV_AW'(item_i.table_address)] <= item_i.envelope_level;
    end
    wave_rd_q <= wave_mem[WAVE_AW'(s2_phase_q >> PHASE_FRACTION_BITS)];
    env_rd_q  <= env_mem[ENV_AW'(s2_pos_q >> ENVELOPE_FRACTION_BITS)];
  end

  // phase advance and loop
  always_comb begin
    vcur      = entry_ok_q ? voice_rd_q : '0;
    wrap_at   = ACC_PH_W'(wave_len_q) << PHASE_FRACTION_BITS;
    loop_back = ACC_PH_W'(sustain_len_q) << PHASE_FRACTION_BITS;
    ph_sum    = ACC_PH_W'(vcur.phase) + ACC_PH_W'(vcur.increment);
    ph_back   = ph_sum - loop_back;
    ph_new    = (ph_sum >= wrap_at) ? ph_back[PHASE_W-1:0] : ph_sum[PHASE_W-1:0];
  end

  // envelope advance
  always_comb begin
    attack_at = ACC_PH_W'(attack_len_q) << PHASE_FRACTION_BITS;
    env_limit = LIM_W'(env_len_q) << ENVELOPE_FRACTION_BITS;
    pos_inc   = LIM_W'(s2_pos_q) + 1'b1;
    env_step  = (ACC_PH_W'(s2_phase_q) >= attack_at) && (pos_inc < env_limit)
                && (s2_pos_q != '1);
    pos_new   = env_step ? s2_pos_q + 1'b1 : s2_pos_q;
  end

  // sweep pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q  <= cnt_q;
    s2_addr_q  <= s1_addr_q;
    s2_inc_q   <= vcur.increment;
    s2_phase_q <= ph_new;
    s2_pos_q   <= vcur.env_pos;
    prod_q     <= PROD_W'(wave_rd_q * $signed({1'b0, env_rd_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (in_acc && item_i.op == OP_TICK) begin
      acc_q <= '0;
    end else if (s4_v_q) begin
      acc_q <= acc_q + SUM_W'(prod_q);
    end
  end

  // scale, clip and offset
  always_comb begin
    mix_shr = SHR_W'(acc_q >>> MIX_SHIFT);
    mix_ext = CLIP_W'(mix_shr);
    if (mix_ext > CLIP_W'(MIX_CLIP)) begin
      mix_clip = CLIP_W'(MIX_CLIP);
    end else if (mix_ext < -CLIP_W'(MIX_CLIP)) begin
      mix_clip = -CLIP_W'(MIX_CLIP);
    end else begin
      mix_clip = mix_ext;
    end
    duty_full = mix_clip + CLIP_W'(DUTY_MID);
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_duty_q <= duty_full[DUTY_W-1:0];
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.pwm_duty = out_duty_q;

endmodule

`default_nettype wire

// File: sim/tb_polyphonic_wavetable_mixer.sv
// tb_polyphonic_wavetable_mixer: self-checking bench for the 64-voice wavetable mixer
// drives items, register writes and result back-pressure through the pwmix channel interfaces
// depends on pwmix_pkg, pwmix_if and polyphonic_wavetable_mixer
`default_nettype none

module tb_polyphonic_wavetable_mixer;
  timeunit 1ns;
  timeprecision 1ps;
  import pwmix_pkg::*;

  localparam int DIRECTED_COUNT = 24;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 232;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RESET_CYCLES   = 10;
  localparam int HEAVY_IDLE_PCT = 55;
  localparam int LIGHT_IDLE_PCT = 12;
  localparam int TICK_PCT       = 40;

  typedef struct packed {
    op_e                  op;
    logic [INC_W-1:0]     increment;
    logic [ADDR_W-1:0]    addr;
    logic [SAMPLE_W-1:0]  sample;
    logic [LEVEL_W-1:0]   level;
    logic                 typed;
    logic [DUTY_W-1:0]    duty;
  } stim_row_t;

  typedef struct packed {
    logic pick_random;
    int   wave_len;
    int   sustain_len;
    int   attack_len;
    int   env_len;
    int   note_pct;
  } setting_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b1, 11'd1024},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h7f, 8'h00, 1'b0, 11'd0},
    '{OP_ENV_WR,  16'h0000, 11'd0,    8'h00, 8'hff, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b1, 11'd2040},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h80, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'hffff, 11'd2047, 8'hff, 8'hff, 1'b1, 11'd8},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'hff, 8'h00, 1'b0, 11'd0},
    '{OP_ENV_WR,  16'h0000, 11'd0,    8'h00, 8'h01, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b1, 11'd1023},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h01, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b1, 11'd1024},
    '{OP_ENV_WR,  16'h0000, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h7f, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b1, 11'd1024},
    '{OP_WAVE_WR, 16'h0000, 11'd2047, 8'h80, 8'h00, 1'b0, 11'd0},
    '{OP_ENV_WR,  16'h0000, 11'd2047, 8'h00, 8'hff, 1'b0, 11'd0},
    '{OP_ENV_WR,  16'h0000, 11'd0,    8'h00, 8'h80, 1'b0, 11'd0},
    '{OP_WAVE_WR, 16'h0000, 11'd0,    8'h40, 8'h00, 1'b0, 11'd0},
    '{OP_NOTE_ON, 16'hffff, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_NOTE_ON, 16'h0000, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_NOTE_ON, 16'h0100, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0},
    '{OP_TICK,    16'h0000, 11'd0,    8'h00, 8'h00, 1'b0, 11'd0}
  };

  localparam setting_t PHASE_SETTINGS [PHASE_COUNT] = '{
    '{1'b0, 2048, 2048,    0, 256, 25},
    '{1'b0,    1,    1, 2048,   1, 25},
    '{1'b0, 2048,    1,    0,   2,  5},
    '{1'b0,  300, 2048,  100,   3, 10},
    '{1'b0, 2048, 2048, 2048, 256, 25},
    '{1'b1,    0,    0,    0,   0, 15},
    '{1'b0,   16,    8,    4,   2,  5},
    '{1'b1,    0,    0,    0,   0, 30}
  };

  logic clk = 1'b0;
  logic rst_n;

  pwmix_item_if   item_bus ();
  pwmix_result_if result_bus ();
  pwmix_cfg_if    cfg_bus ();

  polyphonic_wavetable_mixer uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  always #6 clk = ~clk;

  // mixer state as the block should hold it
  logic [LEN_W-1:0]       wave_len_q;
  logic [LEN_W-1:0]       sustain_len_q;
  logic [LEN_W-1:0]       attack_len_q;
  logic [ENV_LEN_W-1:0]   env_len_q;
  logic [INC_W-1:0]       voice_inc [VOICES];
  logic [PHASE_W-1:0]     voice_phase [VOICES];
  logic [ENV_POS_W-1:0]   voice_env_pos [VOICES];
  logic [VOICE_IDX_W-1:0] next_voice;
  logic signed [SAMPLE_W-1:0] wave_mem [WAVE_DEPTH];
  logic [LEVEL_W-1:0]     env_mem [ENVELOPE_DEPTH];

  logic [DUTY_W-1:0] pending_duty [$];
  logic [DUTY_W-1:0] want_duty;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void reset_mixer_state();
    wave_len_q    = LEN_W'(2048);
    sustain_len_q = LEN_W'(2048);
    attack_len_q  = '0;
    env_len_q     = ENV_LEN_W'(256);
    next_voice    = '0;
    for (int v = 0; v < VOICES; v++) begin
      voice_inc[v]     = '0;
      voice_phase[v]   = '0;
      voice_env_pos[v] = '0;
    end
    for (int a = 0; a < WAVE_DEPTH; a++) wave_mem[a] = '0;
    for (int a = 0; a < ENVELOPE_DEPTH; a++) env_mem[a] = '0;
  endfunction

  // one sample tick: advance every voice and mix
  function automatic logic [DUTY_W-1:0] mix_next_sample();
    int          sum;
    int          mixed;
    int          widx;
    int          eidx;
    logic [31:0] wrap_at;
    logic [31:0] loop_back;
    logic [31:0] attack_at;
    logic [31:0] env_limit;
    logic [31:0] ph;
    logic [31:0] pos;
    sum       = 0;
    wrap_at   = 32'(wave_len_q) << PHASE_FRACTION_BITS;
    loop_back = 32'(sustain_len_q) << PHASE_FRACTION_BITS;
    attack_at = 32'(attack_len_q) << PHASE_FRACTION_BITS;
    env_limit = 32'(env_len_q) << ENVELOPE_FRACTION_BITS;
    for (int v = 0; v < VOICES; v++) begin
      ph  = 32'(voice_phase[v]) + 32'(voice_inc[v]);
      pos = 32'(voice_env_pos[v]);
      if (ph >= wrap_at) ph = ph - loop_back;
      ph = ph & 32'h000f_ffff;
      voice_phase[v] = ph[PHASE_W-1:0];
      widx = int'(ph >> PHASE_FRACTION_BITS) % WAVE_DEPTH;
      eidx = int'(pos >> ENVELOPE_FRACTION_BITS) % ENVELOPE_DEPTH;
      sum += int'(env_mem[eidx]) * int'(wave_mem[widx]);
      if (ph >= attack_at && pos + 32'd1 < env_limit && pos < 32'h7fff) begin
        voice_env_pos[v] = ENV_POS_W'(pos + 32'd1);
      end
    end
    mixed = sum >>> MIX_SHIFT;
    if (mixed > MIX_CLIP) mixed = MIX_CLIP;
    else if (mixed < -MIX_CLIP) mixed = -MIX_CLIP;
    return DUTY_W'(DUTY_MID + mixed);
  endfunction

  function automatic void apply_item(input stim_row_t row);
    logic [DUTY_W-1:0] duty;
    case (row.op)
      OP_TICK: begin
        duty = mix_next_sample();
        pending_duty.push_back(row.typed ? row.duty : duty);
      end
      OP_NOTE_ON: begin
        voice_inc[next_voice]     = row.increment;
        voice_phase[next_voice]   = '0;
        voice_env_pos[next_voice] = '0;
        next_voice                = next_voice + 1'b1;
      end
      OP_WAVE_WR: wave_mem[row.addr] = row.sample;
      OP_ENV_WR:  env_mem[row.addr[ENV_AW-1:0]] = row.level;
      default: ;
    endcase
  endfunction

  function automatic stim_row_t random_item(input int note_pct);
    stim_row_t row;
    int        pick;
    pick = $urandom_range(99);
    if (pick < note_pct) row.op = OP_NOTE_ON;
    else if (pick < note_pct + TICK_PCT) row.op = OP_TICK;
    else if (pick < note_pct + TICK_PCT + (100 - note_pct - TICK_PCT) / 2) row.op = OP_WAVE_WR;
    else row.op = OP_ENV_WR;
    case ($urandom_range(3))
      0: row.increment = INC_W'($urandom);
      1: row.increment = INC_W'($urandom_range(1023));
      2: row.increment = INC_W'($urandom_range(4095, 256));
      default: row.increment = $urandom_range(1) ? '1 : '0;
    endcase
    row.addr   = ADDR_W'($urandom);
    row.sample = SAMPLE_W'($urandom);
    row.level  = LEVEL_W'($urandom);
    row.typed  = 1'b0;
    row.duty   = '0;
    return row;
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back item
  task automatic send_item(input stim_row_t row);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_bus.valid = 1'b0;
      @(negedge clk);
    end
    item_bus.op             = row.op;
    item_bus.increment      = row.increment;
    item_bus.table_address  = row.addr;
    item_bus.wave_sample    = row.sample;
    item_bus.envelope_level = row.level;
    item_bus.valid          = 1'b1;
    do @(posedge clk); while (!item_bus.ready);
    apply_item(row);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_e idx, input int value);
    cfg_bus.index = idx;
    cfg_bus.data  = CFG_DATA_W'(value);
    cfg_bus.valid = 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_WAVE_LEN:    wave_len_q    = cfg_bus.data;
      CFG_SUSTAIN_LEN: sustain_len_q = cfg_bus.data;
      CFG_ATTACK_LEN:  attack_len_q  = cfg_bus.data;
      CFG_ENV_LEN:     env_len_q     = cfg_bus.data[ENV_LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // a tick can still be in flight after its predecessor's result, hence the pause
  task automatic wait_until_idle();
    while (pending_duty.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : result_sink
    result_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      result_bus.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_duty.size() == 0) begin
        report_mismatch($sformatf("duty %0d with no tick waiting", result_bus.pwm_duty));
      end else begin
        want_duty = pending_duty.pop_front();
        results_checked++;
        if (result_bus.pwm_duty !== want_duty) begin
          report_mismatch($sformatf("pwm_duty %0d, expected %0d",
                                    result_bus.pwm_duty, want_duty));
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t row;
    setting_t  setting;
    rst_n                   = 1'b0;
    item_bus.valid          = 1'b0;
    item_bus.op             = OP_TICK;
    item_bus.increment      = '0;
    item_bus.table_address  = '0;
    item_bus.wave_sample    = '0;
    item_bus.envelope_level = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = CFG_WAVE_LEN;
    cfg_bus.data            = '0;
    reset_mixer_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // fill both stores so that no tick reads an unwritten entry
    for (int a = 0; a < WAVE_DEPTH; a++) begin
      row        = random_item(0);
      row.op     = OP_WAVE_WR;
      row.addr   = ADDR_W'(a);
      send_item(row);
    end
    for (int a = 0; a < ENVELOPE_DEPTH; a++) begin
      row        = random_item(0);
      row.op     = OP_ENV_WR;
      row.addr   = ADDR_W'(a);
      send_item(row);
    end

    for (int r = 0; r < DIRECTED_COUNT; r++) send_item(DIRECTED_ROWS[r]);
    item_bus.valid = 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      wait_until_idle();
      setting = PHASE_SETTINGS[p];
      if (setting.pick_random) begin
        setting.wave_len    = $urandom_range(2048, 1);
        setting.sustain_len = $urandom_range(2048, 1);
        setting.attack_len  = $urandom_range(2048, 0);
        setting.env_len     = $urandom_range(256, 1);
      end
      write_register(CFG_WAVE_LEN, setting.wave_len);
      write_register(CFG_SUSTAIN_LEN, setting.sustain_len);
      write_register(CFG_ATTACK_LEN, setting.attack_len);
      write_register(CFG_ENV_LEN, setting.env_len);
      cfg_bus.valid = 1'b0;
      case (p % 4)
        0: begin sender_idle_pct = 0;              recv_stall_pct = 0;              end
        1: begin sender_idle_pct = HEAVY_IDLE_PCT; recv_stall_pct = 0;              end
        2: begin sender_idle_pct = 0;              recv_stall_pct = HEAVY_IDLE_PCT; end
        default: begin
          sender_idle_pct = LIGHT_IDLE_PCT;
          recv_stall_pct  = LIGHT_IDLE_PCT;
        end
      endcase
      repeat (PHASE_ITEMS) send_item(random_item(setting.note_pct));
      item_bus.valid = 1'b0;
    end

    wait_until_idle();
    $display("covered %0d items and %0d mix results over %0d register settings,",
             items_sent, results_checked, PHASE_COUNT + 1);
    $display("with free-running, sender-idle, receiver-stall and mixed back-pressure");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
